FILE: rtl/core/crtu_pkg.sv
// Shared types, field layout and instruction constants of the call/return trace unit.
package crtu_pkg;

    // Default table size
    localparam int MAX_SYMBOLS_DEF = 256;

    // Field widths
    localparam int SYMBOL_COUNT_W = 9;
    localparam int ENTRY_INDEX_W  = 8;
    localparam int ADDR_W         = 32;
    localparam int DEPTH_W        = 16;
    localparam int MATCH_IDX_W    = 8;
    localparam int EVENT_W        = 2;

    // Input tdata layout, lowest bit first
    localparam int IN_ENTRY_INDEX_LSB = 0;
    localparam int IN_ENTRY_START_LSB = 8;
    localparam int IN_ENTRY_SIZE_LSB  = 40;
    localparam int IN_ENTRY_FUNC_BIT  = 72;
    localparam int IN_PC_LSB          = 73;
    localparam int IN_INSTR_LSB       = 105;
    localparam int IN_SOURCE_LSB      = 137;
    localparam int IN_TDATA_W         = 176;

    // Output tdata layout, lowest bit first
    localparam int OUT_TDATA_W = 88;

    // Item kinds carried in s_tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_TRACE = 1'b1;

    // Instruction decode constants
    localparam logic [6:0]  OPC_JAL  = 7'd111;
    localparam logic [6:0]  OPC_JALR = 7'd103;
    localparam logic [2:0]  F3_JALR  = 3'd0;
    localparam logic [31:0] RET_WORD = 32'h0000_8067;

    // Event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_CALL    = 2'd0,
        EV_RET     = 2'd1,
        EV_UNKNOWN = 2'd2
    } event_t;

    // Probe link between neighboring cells
    typedef struct packed {
        logic valid;
        logic any_hit;
        logic fn_hit;
    } link_t;

    // Registered decode of a traced jump
    typedef struct packed {
        logic              launch;
        logic              is_ret;
        logic [ADDR_W-1:0] target;
        logic [ADDR_W-1:0] pc;
    } dec_t;

endpackage

FILE: rtl/core/call_return_trace_unit.sv
// Top level of the call/return trace unit: symbol cell chain, depth tracking, result register.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser: cmd; s_tdata: load entry or traced instruction
//  m_*       out  m_tvalid/m_tready  m_tuser: event_res; m_tdata: index, target, depth, pc
//  cfg_*     in   cfg_valid/cfg_ready cfg_data: symbol_count
//
//  A traced JAL/JALR passes these registers in order: the decode register launches the probe
//  when the jump is taken, then the probe passes the register of each table cell, the resolve
//  register and the output register. s_tready returns with the result, so a traced jump
//  occupies the input until its result is shown.
//  Load items and other instructions give no result and leave s_tready high.
//  Reset clears the depth, symbol_count and all control state; table slots hold garbage
//  until loaded. cfg_ready is always high.
//  A finished result waits in the output register while the next item is taken; a second
//  result then holds in the block, and s_tready stays low, until the first is taken.
module call_return_trace_unit #(
    parameter int MAX_SYMBOLS = crtu_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // fields from bit 0: entry_index[7:0], entry_start[39:8], entry_size[71:40],
    // entry_is_func[72], pc[104:73], instruction[136:105], source_value[168:137], zero pad
    input  logic [crtu_pkg::IN_TDATA_W-1:0]     s_tdata,
    // fields from bit 0: cmd
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // fields from bit 0: matched_index[7:0], target[39:8], depth[55:40], pc_out[87:56]
    output logic [crtu_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // fields from bit 0: event_res[1:0]
    output logic [crtu_pkg::EVENT_W-1:0]        m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [crtu_pkg::SYMBOL_COUNT_W-1:0] cfg_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready
);
    import crtu_pkg::*;

    localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [SYMBOL_COUNT_W-1:0]  count_reg;
    logic signed [DEPTH_W-1:0]  depth_reg;
    event_t                     res_event_reg;
    logic [MATCH_IDX_W-1:0]     res_idx_reg;
    logic signed [DEPTH_W-1:0]  res_depth_reg;
    logic                       m_tvalid_reg;
    event_t                     out_event_reg;
    logic [MATCH_IDX_W-1:0]     out_idx_reg;
    logic [ADDR_W-1:0]          out_target_reg;
    logic signed [DEPTH_W-1:0]  out_depth_reg;
    logic [ADDR_W-1:0]          out_pc_reg;

    logic                       s_accept;
    logic                       load_en;
    logic                       trace_en;
    logic                       is_jump;
    dec_t                       dec;
    link_t                      link     [0:MAX_SYMBOLS];
    logic [IDX_W-1:0]           any_idx  [0:MAX_SYMBOLS];
    logic [IDX_W-1:0]           fn_idx   [0:MAX_SYMBOLS];
    link_t                      chain_end;
    logic                       take_ret;
    logic signed [DEPTH_W-1:0]  depth_dec;
    logic signed [DEPTH_W-1:0]  depth_inc;

    // Handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign load_en   = s_accept && (s_tuser == CMD_LOAD);
    assign trace_en  = s_accept && (s_tuser == CMD_TRACE);
    assign cfg_ready = 1'b1;

    // Decode the traced instruction
    crtu_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .trace_en     (trace_en),
        .pc           (s_tdata[IN_PC_LSB +: ADDR_W]),
        .instruction  (s_tdata[IN_INSTR_LSB +: 32]),
        .source_value (s_tdata[IN_SOURCE_LSB +: 32]),
        .is_jump      (is_jump),
        .dec          (dec)
    );

    // Launch the probe at the head of the chain
    assign link[0].valid   = dec.launch;
    assign link[0].any_hit = 1'b0;
    assign link[0].fn_hit  = 1'b0;
    assign any_idx[0]      = '0;
    assign fn_idx[0]       = '0;

    // Chain of table cells
    for (genvar g = 0; g < MAX_SYMBOLS; g++)
    begin : g_cell
        crtu_cell #(
            .CELL_INDEX (g),
            .IDX_W      (IDX_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr_en       (load_en),
            .wr_index    (s_tdata[IN_ENTRY_INDEX_LSB +: ENTRY_INDEX_W]),
            .wr_start    (s_tdata[IN_ENTRY_START_LSB +: 32]),
            .wr_size     (s_tdata[IN_ENTRY_SIZE_LSB +: 32]),
            .wr_func     (s_tdata[IN_ENTRY_FUNC_BIT]),
            .target      (dec.target),
            .count       (count_reg),
            .link_in     (link[g]),
            .any_idx_in  (any_idx[g]),
            .fn_idx_in   (fn_idx[g]),
            .link_out    (link[g+1]),
            .any_idx_out (any_idx[g+1]),
            .fn_idx_out  (fn_idx[g+1])
        );
    end

    assign chain_end = link[MAX_SYMBOLS];

    // Resolve the event at the end of the chain
    assign take_ret  = dec.is_ret && chain_end.any_hit;
    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign depth_inc = depth_reg + DEPTH_W'(1);

    // Sequencer, depth, config and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            // Fill the output register when it frees up, else drop a taken item
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (trace_en && is_jump)
                    begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (chain_end.valid)
                    begin
                        if (take_ret)
                        begin
                            res_event_reg <= EV_RET;
                            res_idx_reg   <= MATCH_IDX_W'(any_idx[MAX_SYMBOLS]);
                            res_depth_reg <= depth_dec;
                            depth_reg     <= depth_dec;
                        end
                        else if (chain_end.fn_hit)
                        begin
                            res_event_reg <= EV_CALL;
                            res_idx_reg   <= MATCH_IDX_W'(fn_idx[MAX_SYMBOLS]);
                            res_depth_reg <= depth_reg;
                            depth_reg     <= depth_inc;
                        end
                        else
                        begin
                            res_event_reg <= EV_UNKNOWN;
                            res_idx_reg   <= '0;
                            res_depth_reg <= depth_reg;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        out_event_reg  <= res_event_reg;
                        out_idx_reg    <= res_idx_reg;
                        out_target_reg <= dec.target;
                        out_depth_reg  <= res_depth_reg;
                        out_pc_reg     <= dec.pc;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output item
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {out_pc_reg, out_depth_reg, out_target_reg, out_idx_reg};

endmodule

FILE: rtl/core/crtu_decode.sv
// Jump decode stage: target formation and launch of a probe into the cell chain.
module crtu_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    trace_en,
    input  logic [31:0]             pc,
    input  logic [31:0]             instruction,
    input  logic [31:0]             source_value,
    output logic                    is_jump,
    output crtu_pkg::dec_t          dec
);
    import crtu_pkg::*;

    logic        is_jal;
    logic        is_jalr;
    logic [31:0] imm_i;
    logic [31:0] imm_j;
    logic [31:0] target_now;
    logic        launch_reg;
    logic        is_ret_reg;
    logic [31:0] target_reg;
    logic [31:0] pc_reg;

    // Classify the instruction
    assign is_jal  = (instruction[6:0] == OPC_JAL);
    assign is_jalr = (instruction[6:0] == OPC_JALR) && (instruction[14:12] == F3_JALR);
    assign is_jump = is_jal || is_jalr;

    // Form the immediates and the jump target
    assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};
    assign target_now = is_jal ? (pc + imm_j) : (source_value + imm_i);

    // Pulse launch for one cycle per traced jump
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= trace_en && is_jump;
        end
    end

    // Hold the decoded jump until the next traced jump
    always_ff @(posedge clk)
    begin
        if (trace_en && is_jump)
        begin
            is_ret_reg <= (instruction == RET_WORD);
            target_reg <= target_now;
            pc_reg     <= pc;
        end
    end

    assign dec.launch = launch_reg;
    assign dec.is_ret = is_ret_reg;
    assign dec.target = target_reg;
    assign dec.pc     = pc_reg;

endmodule

FILE: rtl/core/crtu_cell.sv
// One symbol table cell: holds one address range and checks the passing probe against it.
module crtu_cell #(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [crtu_pkg::ENTRY_INDEX_W-1:0]   wr_index,
    input  logic [31:0]                          wr_start,
    input  logic [31:0]                          wr_size,
    input  logic                                 wr_func,
    input  logic [31:0]                          target,
    input  logic [crtu_pkg::SYMBOL_COUNT_W-1:0]  count,
    input  crtu_pkg::link_t                      link_in,
    input  logic [IDX_W-1:0]                     any_idx_in,
    input  logic [IDX_W-1:0]                     fn_idx_in,
    output crtu_pkg::link_t                      link_out,
    output logic [IDX_W-1:0]                     any_idx_out,
    output logic [IDX_W-1:0]                     fn_idx_out
);
    import crtu_pkg::*;

    localparam int SEL_W = (IDX_W > ENTRY_INDEX_W) ? IDX_W : ENTRY_INDEX_W;
    localparam int CMP_W = (IDX_W + 1 > SYMBOL_COUNT_W) ? IDX_W + 1 : SYMBOL_COUNT_W;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic        sel;
    logic        active;
    logic        in_range;
    logic [31:0] start_reg;
    logic [32:0] end_reg;
    logic        func_reg;
    link_t       link_reg;
    logic [IDX_W-1:0] any_idx_reg;
    logic [IDX_W-1:0] fn_idx_reg;

    // Load the range; keep the end address one bit wider so it never wraps
    assign sel = wr_en && (SEL_W'(wr_index) == SEL_W'(CELL_INDEX));

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            start_reg <= wr_start;
            end_reg   <= {1'b0, wr_start} + {1'b0, wr_size};
            func_reg  <= wr_func;
        end
    end

    // Match only cells below the loaded symbol count
    assign active   = CMP_W'(count) > CMP_W'(CELL_INDEX);
    assign in_range = active && (target >= start_reg) && ({1'b0, target} < end_reg);

    // Advance the probe; the first hit along the chain is kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg.valid   <= link_in.valid;
            link_reg.any_hit <= link_in.any_hit || in_range;
            link_reg.fn_hit  <= link_in.fn_hit || (in_range && func_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        any_idx_reg <= (!link_in.any_hit && in_range) ? MY_IDX : any_idx_in;
        fn_idx_reg  <= (!link_in.fn_hit && in_range && func_reg) ? MY_IDX : fn_idx_in;
    end

    assign link_out    = link_reg;
    assign any_idx_out = any_idx_reg;
    assign fn_idx_out  = fn_idx_reg;

endmodule

FILE: rtl/core/crtu_checker.sv
// Port-level checks of the call/return trace unit and their binding to the top level.
module crtu_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [crtu_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [crtu_pkg::EVENT_W-1:0]     m_tuser
);
    import crtu_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Use only defined event codes
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == EV_CALL) || (m_tuser == EV_RET) || (m_tuser == EV_UNKNOWN))
        else $error("undefined event code");

    // Report slot zero for an unknown transfer
    a_unknown_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == EV_UNKNOWN) |-> (m_tdata[7:0] == 8'd0))
        else $error("unknown event with nonzero slot");

    // Stay ready after a load item
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_LOAD) |=> s_tready)
        else $error("load item blocked input");

endmodule

bind call_return_trace_unit crtu_checker u_crtu_checker (.*);
